/* design/pwmd_pkg.sv */
package pwmd_pkg;

   // Run storage geometry
   localparam int MAX_PAIRS = 64;
   localparam int IDX_W     = $clog2(MAX_PAIRS);
   localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
   localparam int USED_W    = 7;

   // Two store banks, one per queued run
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W      = IDX_W + 1;
   localparam int STORE_DEPTH = 2 * MAX_PAIRS;

   // Microsecond fields
   localparam int US_W = 16;
   localparam logic [US_W-1:0] US_MAX = '1;

   // Tolerance: floor(s * TOLERANCE_PCT / 100) as s * TOL_RECIP >> RECIP_SHIFT
   localparam int TOLERANCE_PCT = 20;
   localparam int RECIP_SHIFT   = 24;
   localparam int RECIP_W       = 24;
   localparam int PROD_W        = US_W + RECIP_W;
   localparam logic [RECIP_W-1:0] TOL_RECIP =
      RECIP_W'((TOLERANCE_PCT * (1 << RECIP_SHIFT) + 99) / 100);

   // Result status codes
   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] ST_BIT_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_WIDTH = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SEQ   = 2'd2;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PULSE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GAP   = 2'd3;

   // Classified pair as kept in the store
   typedef struct packed {
      logic            pulse_ok;
      logic            gap_ok;
      logic [US_W-1:0] pulse;
   } entry_type;

   // Store write from the front end
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } store_wr_type;

   // One closed run waiting to be decoded
   typedef struct packed {
      logic            bank;
      logic [CNT_W-1:0] count;
      logic [US_W-1:0] shortest;
      logic            no_width;
   } job_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* design/pwmd_front.sv */
module pwmd_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,   // pulse_us[15:0], gap_us[31:16]
   input  logic                              req_tlast,   // last_pair
   input  logic                              csr_we,
   input  logic [pwmd_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  logic [pwmd_pkg::US_W-1:0]         csr_wdata,
   input  pwmd_pkg::queue_status_type        q_status,
   output logic                              push,
   output pwmd_pkg::job_type                 push_job,
   output pwmd_pkg::store_wr_type            store_wr
);

   logic [pwmd_pkg::US_W-1:0]  min_pulse_ff, max_pulse_ff, min_gap_ff, max_gap_ff;
   logic [pwmd_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       bank_ff, bank_in;
   logic [pwmd_pkg::US_W-1:0]  short_ff, short_in, long_ff, long_in;

   logic [pwmd_pkg::US_W-1:0]  pulse, gap, cur_short, cur_long;
   logic [pwmd_pkg::CNT_W-1:0] cnt_next;
   logic                       accept, gap_ok, pulse_ok, measure, close;

   assign pulse      = req_tdata[15:0];
   assign gap        = req_tdata[31:16];
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   // Classify the incoming pair
   assign gap_ok   = (gap >= min_gap_ff) && (gap <= max_gap_ff);
   assign pulse_ok = (pulse <= max_pulse_ff);
   assign measure  = gap_ok && pulse_ok && (pulse > min_pulse_ff);

   // Track shortest and longest qualifying pulse while loading
   assign cur_short = (cnt_ff == '0) ? pwmd_pkg::US_MAX : short_ff;
   assign cur_long  = (cnt_ff == '0) ? '0 : long_ff;
   assign short_in  = (measure && (pulse < cur_short)) ? pulse : cur_short;
   assign long_in   = (measure && (pulse > cur_long)) ? pulse : cur_long;

   assign cnt_next = cnt_ff + pwmd_pkg::CNT_W'(1);
   assign close    = req_tlast || (cnt_next == pwmd_pkg::CNT_W'(pwmd_pkg::MAX_PAIRS));

   assign cnt_in  = close ? '0 : cnt_next;
   assign bank_in = close ? !bank_ff : bank_ff;

   // Store write for every accepted pair
   assign store_wr.en            = accept;
   assign store_wr.addr          = {bank_ff, cnt_ff[pwmd_pkg::IDX_W-1:0]};
   assign store_wr.data.pulse_ok = pulse_ok;
   assign store_wr.data.gap_ok   = gap_ok;
   assign store_wr.data.pulse    = pulse;

   // Hand the closed run to the decoder
   assign push              = accept && close;
   assign push_job.bank     = bank_ff;
   assign push_job.count    = cnt_next;
   assign push_job.shortest = short_in;
   assign push_job.no_width = (short_in == pwmd_pkg::US_MAX) || (long_in == '0);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulse_ff <= '0;
         max_pulse_ff <= pwmd_pkg::US_MAX;
         min_gap_ff   <= '0;
         max_gap_ff   <= pwmd_pkg::US_MAX;
      end else if (csr_we) begin
         case (csr_addr)
            pwmd_pkg::CSR_MIN_PULSE: min_pulse_ff <= csr_wdata;
            pwmd_pkg::CSR_MAX_PULSE: max_pulse_ff <= csr_wdata;
            pwmd_pkg::CSR_MIN_GAP:   min_gap_ff   <= csr_wdata;
            pwmd_pkg::CSR_MAX_GAP:   max_gap_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Load counter, bank select and width trackers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         bank_ff  <= 1'b0;
         short_ff <= pwmd_pkg::US_MAX;
         long_ff  <= '0;
      end else if (accept) begin
         cnt_ff   <= cnt_in;
         bank_ff  <= bank_in;
         short_ff <= short_in;
         long_ff  <= long_in;
      end
   end

endmodule

/* design/pwmd_queue.sv */
module pwmd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pwmd_pkg::job_type          push_job,
   input  logic                       pop,
   output pwmd_pkg::job_type          head,
   output pwmd_pkg::queue_status_type status
);

   pwmd_pkg::job_type           slot_ff [pwmd_pkg::QUEUE_DEPTH];
   logic [pwmd_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [pwmd_pkg::QCNT_W-1:0] count_ff;
   logic                        do_push, do_pop;

   assign status.full  = (count_ff == pwmd_pkg::QCNT_W'(pwmd_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = slot_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   // Hold job descriptors
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + pwmd_pkg::QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + pwmd_pkg::QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + pwmd_pkg::QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - pwmd_pkg::QCNT_W'(1);
         end
      end
   end

endmodule

/* design/pwmd_back.sv */
module pwmd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  pwmd_pkg::store_wr_type     store_wr,
   input  pwmd_pkg::job_type          head,
   input  pwmd_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,   // bit_value[0], status[2:1], pairs_consumed[9:3]
   output logic                       rsp_tlast    // last_result
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_TOL,
      S_READ,
      S_EVAL,
      S_FINAL
   } state_type;

   pwmd_pkg::entry_type store [pwmd_pkg::STORE_DEPTH];

   state_type                       state_ff, state_in;
   logic [pwmd_pkg::CNT_W-1:0]      idx_ff, idx_in, used_ff, used_in;
   logic                            pend_ff, pend_in, have_ff, have_in;
   logic [pwmd_pkg::STATUS_W-1:0]   fin_st_ff, fin_st_in;
   logic [pwmd_pkg::PROD_W-1:0]     prod_ff;
   logic [pwmd_pkg::US_W-1:0]       tol_ff;
   pwmd_pkg::entry_type             rd_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_bit_ff, rsp_bit_in, rsp_last_ff, rsp_last_in;
   logic [pwmd_pkg::STATUS_W-1:0]   rsp_st_ff, rsp_st_in;
   logic [pwmd_pkg::USED_W-1:0]     rsp_used_ff, rsp_used_in;

   logic                            out_free, emit, rd_en, bit_val;
   logic [pwmd_pkg::US_W-1:0]       diff;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rd_en    = (state_ff == S_READ) && (idx_ff != head.count);

   // Distance of the stored pulse from the shortest width
   assign diff    = (rd_ff.pulse > head.shortest) ? rd_ff.pulse - head.shortest
                                                  : head.shortest - rd_ff.pulse;
   assign bit_val = (diff > tol_ff);

   // Store: written by the front end, read one entry per decode step
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store[store_wr.addr] <= store_wr.data;
      end
      if (rd_en) begin
         rd_ff <= store[{head.bank, idx_ff[pwmd_pkg::IDX_W-1:0]}];
      end
   end

   // Tolerance multiply, then scale
   always_ff @(posedge clock) begin
      prod_ff <= pwmd_pkg::PROD_W'(head.shortest) * pwmd_pkg::PROD_W'(pwmd_pkg::TOL_RECIP);
      tol_ff  <= prod_ff[pwmd_pkg::RECIP_SHIFT +: pwmd_pkg::US_W];
   end

   // Decode sequencer
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      used_in     = used_ff;
      pend_in     = pend_ff;
      have_in     = have_ff;
      fin_st_in   = fin_st_ff;
      emit        = 1'b0;
      pop         = 1'b0;
      rsp_bit_in  = rsp_bit_ff;
      rsp_st_in   = rsp_st_ff;
      rsp_used_in = rsp_used_ff;
      rsp_last_in = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            idx_in  = '0;
            have_in = 1'b0;
            if (!q_status.empty) begin
               if (head.no_width) begin
                  fin_st_in = pwmd_pkg::ST_NO_WIDTH;
                  state_in  = S_FINAL;
               end else begin
                  state_in = S_TOL;
               end
            end
         end
         S_TOL: begin
            state_in = S_READ;
         end
         S_READ: begin
            if (idx_ff == head.count) begin
               fin_st_in = pwmd_pkg::ST_NO_SEQ;
               used_in   = head.count;
               state_in  = S_FINAL;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!rd_ff.gap_ok) begin
               idx_in   = idx_ff + pwmd_pkg::CNT_W'(1);
               state_in = S_READ;
            end else if (rd_ff.pulse_ok) begin
               // Release the pending bit once the next one is known
               if (!have_ff || out_free) begin
                  if (have_ff) begin
                     emit        = 1'b1;
                     rsp_bit_in  = pend_ff;
                     rsp_st_in   = pwmd_pkg::ST_BIT_OK;
                     rsp_used_in = '0;
                     rsp_last_in = 1'b0;
                  end
                  pend_in  = bit_val;
                  have_in  = 1'b1;
                  idx_in   = idx_ff + pwmd_pkg::CNT_W'(1);
                  state_in = S_READ;
               end
            end else if (have_ff) begin
               // Over-long pulse ends the sequence
               used_in  = idx_ff + pwmd_pkg::CNT_W'(1);
               state_in = S_FINAL;
            end else begin
               idx_in   = idx_ff + pwmd_pkg::CNT_W'(1);
               state_in = S_READ;
            end
         end
         S_FINAL: begin
            if (out_free) begin
               emit        = 1'b1;
               pop         = 1'b1;
               rsp_last_in = 1'b1;
               if (have_ff) begin
                  rsp_bit_in  = pend_ff;
                  rsp_st_in   = pwmd_pkg::ST_BIT_OK;
                  rsp_used_in = pwmd_pkg::USED_W'(used_ff);
               end else begin
                  rsp_bit_in  = 1'b0;
                  rsp_st_in   = fin_st_ff;
                  rsp_used_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         used_ff      <= '0;
         have_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         fin_st_ff    <= pwmd_pkg::ST_BIT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         used_ff      <= used_in;
         have_ff      <= have_in;
         pend_ff      <= pend_in;
         fin_st_ff    <= fin_st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_bit_ff  <= rsp_bit_in;
         rsp_st_ff   <= rsp_st_in;
         rsp_used_ff <= rsp_used_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'b0, rsp_used_ff, rsp_st_ff, rsp_bit_ff};

endmodule

/* design/pwm_pulse_width_bit_decoder.sv */
// Channel  | Direction | Handshake             | Payload
// req      | in        | req_tvalid/req_tready | tdata: pulse_us, gap_us; tlast: last_pair
// rsp      | out       | rsp_tvalid/rsp_tready | tdata: bit_value, status, pairs_consumed;
//          |           |                       | tlast: last_result
// csr      | in        | csr_we                | csr_addr register index, csr_wdata value
//
// Loading takes one pair per cycle unless req stalls, and tracks widths; runs with no usable width skip the walk.
// Decoding runs setup (idle, then tolerance), a store read then an evaluate for each walked pair,
// an end-of-run read unless an over-long pulse stops the walk, and a final-result step.
// Two store banks let the next run load while the previous one decodes; req stalls
// only while both banks hold undecoded runs. rsp stalls hold the decoder in place.
// Reset is synchronous and clears control state only; the store is not cleared.
module pwm_pulse_width_bit_decoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // pulse_us[15:0], gap_us[31:16]
   input  logic                           req_tlast,   // last_pair
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,   // bit_value[0], status[2:1], pairs_consumed[9:3]
   output logic                           rsp_tlast,   // last_result
   input  logic                           csr_we,
   input  logic [pwmd_pkg::CSR_IDX_W-1:0] csr_addr,
   input  logic [pwmd_pkg::US_W-1:0]      csr_wdata
);

   pwmd_pkg::queue_status_type q_status;
   pwmd_pkg::job_type          push_job, head;
   pwmd_pkg::store_wr_type     store_wr;
   logic                       push, pop;

   pwmd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .push       (push),
      .push_job   (push_job),
      .store_wr   (store_wr)
   );

   pwmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   pwmd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .store_wr   (store_wr),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* design/pwmd_checker.sv */
module pwmd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [31:0]                    req_tdata,
   input logic                           req_tlast,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [15:0]                    rsp_tdata,
   input logic                           rsp_tlast,
   input logic                           csr_we,
   input logic [pwmd_pkg::CSR_IDX_W-1:0] csr_addr,
   input logic [pwmd_pkg::US_W-1:0]      csr_wdata
);

   // Stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // Reset drops any pending result
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Failure results close the run and carry no bit or count
   a_fail_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:1] != pwmd_pkg::ST_BIT_OK) |->
         rsp_tlast && !rsp_tdata[0] && (rsp_tdata[9:3] == '0) &&
         ((rsp_tdata[2:1] == pwmd_pkg::ST_NO_WIDTH) || (rsp_tdata[2:1] == pwmd_pkg::ST_NO_SEQ)))
      else $error("malformed failure result");

   // Only the closing result reports a pair count
   a_mid_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
         (rsp_tdata[9:3] == '0) && (rsp_tdata[2:1] == pwmd_pkg::ST_BIT_OK))
      else $error("non-final result carries a count or failure");

   // Closing bit result consumed at least one pair, at most a full bank
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && (rsp_tdata[2:1] == pwmd_pkg::ST_BIT_OK) |->
         (rsp_tdata[9:3] != '0) && (rsp_tdata[9:3] <= 7'(pwmd_pkg::MAX_PAIRS)) &&
         (rsp_tdata[15:10] == '0))
      else $error("pair count out of range");

endmodule

bind pwm_pulse_width_bit_decoder pwmd_checker u_pwmd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_we     (csr_we),
   .csr_addr   (csr_addr),
   .csr_wdata  (csr_wdata)
);
